/* rtl/core/dfe_pkg.sv */
// Shared types and constants of the digitizer event feature extractor.
`default_nettype none

package dfe_pkg;

    // Stream widths
    localparam int IN_W  = 32;
    localparam int OUT_W = 248;

    // Field widths
    localparam int CH_W    = 12;
    localparam int TS_W    = 48;
    localparam int FMT_W   = 4;
    localparam int CNT_W   = 27;
    localparam int SMP_W   = 16;
    localparam int HLEN_W  = 5;

    // Buffer header word positions
    localparam logic [2:0] HDR_CHANNEL = 3'd3;
    localparam logic [2:0] HDR_EVENTS  = 3'd4;
    localparam logic [2:0] HDR_WORDS   = 3'd5;
    localparam logic [2:0] HDR_FILTER  = 3'd6;
    localparam logic [2:0] HDR_LAST    = 3'd7;

    // Event header lengths
    localparam logic [HLEN_W-1:0] HLEN_BASE = 5'd3;
    localparam logic [HLEN_W-1:0] HLEN_FMT0 = 5'd7;
    localparam logic [HLEN_W-1:0] HLEN_FMT1 = 5'd2;
    localparam logic [HLEN_W-1:0] HLEN_FMT2 = 5'd3;
    localparam logic [HLEN_W-1:0] HLEN_FMT3 = 5'd2;

    // Start values of the running extremes
    localparam logic [SMP_W-1:0] SAMPLE_MIN_START = 16'd16384;
    localparam logic [31:0]      FILTER_MIN_START = 32'h7fff_ffff;
    localparam logic [31:0]      FILTER_OFFSET    = 32'h0800_0000;

    // Result item, lowest field last
    typedef struct packed {
        logic               pad;
        logic signed [31:0] filter_min;
        logic signed [31:0] filter_max;
        logic [SMP_W-1:0]   sample_min;
        logic [CNT_W-1:0]   sample_max_index;
        logic [SMP_W-1:0]   sample_max;
        logic [CNT_W-1:0]   sample_count;
        logic [FMT_W-1:0]   header_format;
        logic [31:0]        event_number;
        logic [TS_W-1:0]    timestamp;
        logic               channel_mismatch;
        logic [CH_W-1:0]    channel;
    } result_t;

endpackage

`default_nettype wire

/* rtl/core/digitizer_event_feature_extractor.sv */
// Top level of the digitizer event feature extractor.
`default_nettype none

// Takes a digitizer readout stream one 32-bit word per item: an 8-word buffer
// header (channel, event count, words per event, filter word count), then the
// events back to back. The first event of a buffer fixes the format bits,
// the event header length and the sample count. One result item leaves on the
// last word of each event with channel, timestamp, sample and filter extremes.
// Every word is handled by the logic between the state registers and the
// result register, so one word per cycle is taken while input does not stall. A
// result sits in an output register backed by one skid entry; input stalls
// only when both hold a result not yet taken.
module digitizer_event_feature_extractor (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [dfe_pkg::IN_W-1:0]  s_tdata,  // [31:0] word
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [11:0] channel, [12] channel_mismatch, [60:13] timestamp,
    // [92:61] event_number, [96:93] header_format, [123:97] sample_count,
    // [139:124] sample_max, [166:140] sample_max_index, [182:167] sample_min,
    // [214:183] filter_max, [246:215] filter_min, [247] zero
    output logic [dfe_pkg::OUT_W-1:0] m_tdata
);
    import dfe_pkg::*;

    localparam logic PHASE_HEADER = 1'b0;
    localparam logic PHASE_EVENT  = 1'b1;

    // State registers
    logic               phase_reg,            phase_next;
    logic [2:0]         hdr_count_reg,        hdr_count_next;
    logic [31:0]        buffer_channel_reg,   buffer_channel_next;
    logic [31:0]        events_total_reg,     events_total_next;
    logic [31:0]        event_words_reg,      event_words_next;
    logic [31:0]        filter_count_reg,     filter_count_next;
    logic [FMT_W-1:0]   format_reg,           format_next;
    logic [HLEN_W-1:0]  hlen_reg,             hlen_next;
    logic [CNT_W-1:0]   samples_reg,          samples_next;
    logic               first_event_reg,      first_event_next;
    logic [31:0]        word_idx_reg,         word_idx_next;
    logic [31:0]        event_count_reg,      event_count_next;
    logic [31:0]        first_word_reg,       first_word_next;
    logic [31:0]        time_low_reg,         time_low_next;
    logic [SMP_W-1:0]   smax_reg,             smax_next;
    logic [CNT_W-1:0]   smax_idx_reg,         smax_idx_next;
    logic [SMP_W-1:0]   smin_reg,             smin_next;
    logic signed [31:0] fmax_reg,             fmax_next;
    logic signed [31:0] fmin_reg,             fmin_next;

    // Output register and skid entry
    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;

    logic    take;
    logic    emit;
    result_t res;

    // Working values of the event path
    logic [HLEN_W-1:0]  hl;
    logic [CNT_W-1:0]   s_end;
    logic [32:0]        f_end;
    logic [31:0]        rel;
    logic [CNT_W-1:0]   base;
    logic               in_samples, in_filter;
    logic [SMP_W-1:0]   s_lo, s_hi, max_a, min_a;
    logic [CNT_W-1:0]   idx_a;
    logic signed [31:0] fval;
    logic [31:0]        count_inc;
    logic [CH_W-1:0]    ch;

    assign s_tready = !skid_valid_reg;
    assign take     = s_tvalid && s_tready;

    // Work out the next state and the result of the current word
    always_comb
    begin
        phase_next          = phase_reg;
        hdr_count_next      = hdr_count_reg;
        buffer_channel_next = buffer_channel_reg;
        events_total_next   = events_total_reg;
        event_words_next    = event_words_reg;
        filter_count_next   = filter_count_reg;
        format_next         = format_reg;
        hlen_next           = hlen_reg;
        samples_next        = samples_reg;
        first_event_next    = first_event_reg;
        word_idx_next       = word_idx_reg;
        event_count_next    = event_count_reg;
        first_word_next     = first_word_reg;
        time_low_next       = time_low_reg;
        smax_next           = smax_reg;
        smax_idx_next       = smax_idx_reg;
        smin_next           = smin_reg;
        fmax_next           = fmax_reg;
        fmin_next           = fmin_reg;
        emit                = 1'b0;

        // Region bounds from the registered header length and sample count
        hl         = hlen_reg;
        s_end      = CNT_W'(hl) + CNT_W'(samples_reg[CNT_W-1:1]);
        f_end      = 33'(s_end) + 33'(filter_count_reg);
        rel        = word_idx_reg - 32'(hl);
        base       = {rel[CNT_W-2:0], 1'b0};
        in_samples = (word_idx_reg >= 32'(hl)) && (word_idx_reg < 32'(s_end));
        in_filter  = (word_idx_reg >= 32'(s_end)) && ({1'b0, word_idx_reg} < f_end);
        s_lo       = s_tdata[15:0];
        s_hi       = s_tdata[31:16];
        fval       = s_tdata - FILTER_OFFSET;
        count_inc  = event_count_reg + 32'd1;
        max_a      = smax_reg;
        idx_a      = smax_idx_reg;
        min_a      = smin_reg;

        if (take)
        begin
            if (phase_reg == PHASE_HEADER)
            begin
                // Capture the buffer header words
                case (hdr_count_reg)
                    HDR_CHANNEL: buffer_channel_next = s_tdata;
                    HDR_EVENTS:  events_total_next   = s_tdata;
                    HDR_WORDS:   event_words_next    = s_tdata;
                    HDR_FILTER:  filter_count_next   = s_tdata;
                    default:     ;
                endcase
                if (hdr_count_reg == HDR_LAST)
                begin
                    hdr_count_next = 3'd0;
                    if (events_total_reg != 32'd0 && event_words_reg != 32'd0)
                    begin
                        phase_next       = PHASE_EVENT;
                        event_count_next = 32'd0;
                        word_idx_next    = 32'd0;
                        first_event_next = 1'b1;
                    end
                end
                else
                begin
                    hdr_count_next = hdr_count_reg + 3'd1;
                end
            end
            else
            begin
                // Event word 0 opens the event and resets the extremes
                if (word_idx_reg == 32'd0)
                begin
                    first_word_next = s_tdata;
                    time_low_next   = 32'd0;
                    if (first_event_reg)
                    begin
                        format_next  = s_tdata[FMT_W-1:0];
                        hl = HLEN_BASE
                           + (s_tdata[0] ? HLEN_FMT0 : '0)
                           + (s_tdata[1] ? HLEN_FMT1 : '0)
                           + (s_tdata[2] ? HLEN_FMT2 : '0)
                           + (s_tdata[3] ? HLEN_FMT3 : '0);
                        hlen_next    = hl;
                        samples_next = '0;
                    end
                    smax_next     = '0;
                    smax_idx_next = '0;
                    smin_next     = SAMPLE_MIN_START;
                    fmax_next     = '0;
                    fmin_next     = FILTER_MIN_START;
                end
                else if (word_idx_reg == 32'd1)
                begin
                    time_low_next = s_tdata;
                end

                // Latch the sample count from the first event's count word
                if (first_event_reg && word_idx_reg == 32'(hl) - 32'd1)
                    samples_next = {s_tdata[CNT_W-2:0], 1'b0};

                if (in_samples)
                begin
                    // Low half first, then high half
                    if (s_lo > max_a)
                    begin
                        max_a = s_lo;
                        idx_a = base;
                    end
                    if (s_lo < min_a)
                        min_a = s_lo;
                    if (s_hi > max_a)
                    begin
                        max_a = s_hi;
                        idx_a = {rel[CNT_W-2:0], 1'b1};
                    end
                    if (s_hi < min_a)
                        min_a = s_hi;
                    smax_next     = max_a;
                    smax_idx_next = idx_a;
                    smin_next     = min_a;
                end
                else if (in_filter)
                begin
                    if (fval > fmax_reg)
                        fmax_next = fval;
                    if (fval < fmin_reg)
                        fmin_next = fval;
                end

                // Close the event on its last word
                if (word_idx_reg == event_words_reg - 32'd1)
                begin
                    emit             = 1'b1;
                    event_count_next = count_inc;
                    word_idx_next    = 32'd0;
                    first_event_next = 1'b0;
                    if (count_inc == events_total_reg)
                    begin
                        phase_next     = PHASE_HEADER;
                        hdr_count_next = 3'd0;
                    end
                end
                else
                begin
                    word_idx_next = word_idx_reg + 32'd1;
                end
            end
        end

        // Assemble the result item
        ch                   = first_word_next[15:4];
        res.pad              = 1'b0;
        res.channel          = ch;
        res.channel_mismatch = (32'(ch) != buffer_channel_reg);
        res.timestamp        = {first_word_next[31:16], time_low_next};
        res.event_number     = event_count_reg;
        res.header_format    = format_next;
        res.sample_count     = samples_next;
        res.sample_max       = smax_next;
        res.sample_max_index = smax_idx_next;
        res.sample_min       = smin_next;
        res.filter_max       = fmax_next;
        res.filter_min       = fmin_next;
    end

    // Advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PHASE_HEADER;
            hdr_count_reg      <= '0;
            buffer_channel_reg <= '0;
            events_total_reg   <= '0;
            event_words_reg    <= '0;
            filter_count_reg   <= '0;
            format_reg         <= '0;
            hlen_reg           <= HLEN_BASE;
            samples_reg        <= '0;
            first_event_reg    <= 1'b1;
            word_idx_reg       <= '0;
            event_count_reg    <= '0;
            first_word_reg     <= '0;
            time_low_reg       <= '0;
            smax_reg           <= '0;
            smax_idx_reg       <= '0;
            smin_reg           <= SAMPLE_MIN_START;
            fmax_reg           <= '0;
            fmin_reg           <= FILTER_MIN_START;
        end
        else
        begin
            phase_reg          <= phase_next;
            hdr_count_reg      <= hdr_count_next;
            buffer_channel_reg <= buffer_channel_next;
            events_total_reg   <= events_total_next;
            event_words_reg    <= event_words_next;
            filter_count_reg   <= filter_count_next;
            format_reg         <= format_next;
            hlen_reg           <= hlen_next;
            samples_reg        <= samples_next;
            first_event_reg    <= first_event_next;
            word_idx_reg       <= word_idx_next;
            event_count_reg    <= event_count_next;
            first_word_reg     <= first_word_next;
            time_low_reg       <= time_low_next;
            smax_reg           <= smax_next;
            smax_idx_reg       <= smax_idx_next;
            smin_reg           <= smin_next;
            fmax_reg           <= fmax_next;
            fmin_reg           <= fmin_next;
        end
    end

    // Hold results in the output register, spill into the skid entry on stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (m_tready || !out_valid_reg)
        begin
            out_valid_reg  <= skid_valid_reg || emit;
            skid_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_tready || !out_valid_reg)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (emit)
                out_reg <= res;
        end
        else if (emit)
        begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

`default_nettype wire
